[sv/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define AST_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define AST_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[sv/oah_pkg.sv]
// ---------------------------------------------------------------------------
// oah_pkg
// Constants and helpers for the open-address hash insert block.
// ---------------------------------------------------------------------------
package oah_pkg;

  localparam int DEF_TABLE_DEPTH = 1024;
  localparam int DEF_KEY_LEN     = 8;
  localparam int POWER_CYCLE     = 6;
  localparam int MAX_SPAN        = 8;
  localparam int ACC_W           = 44;
  localparam int POW_W           = 40;

  localparam int TSIZE_W = 11;
  localparam int SPAN_W  = 4;
  localparam int CFG_W   = 11;
  localparam int CIDX_W  = 2;

  localparam logic [CIDX_W-1:0] CFG_SLOT_LIMIT = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_PROBE_MODE = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_HASH_SPAN  = 2'd2;

  localparam logic [1:0] STAT_NEW   = 2'd0;
  localparam logic [1:0] STAT_FOUND = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    fold_case = (c inside {[8'd65:8'd90]}) ? c + 8'd32 : c;
  endfunction

endpackage

[sv/open_address_hash_insert_top.sv]
// ---------------------------------------------------------------------------
// open_address_hash_insert_top
// Hashes a key streamed one character per word and inserts it into an
// open-addressing table held in one synchronous memory.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one key character per word; in_key_last marks the final one,
//           and only that word produces a result word.
//   out_* : slot, probe steps, status, filled count, saturating probe sum.
//   cfg_* : slot limit, probe mode, hash span; always ready, write only
//           while no key is in flight.
// Flow: a character word passes S_IDLE, S_POW and S_ACC; S_POW raises the
//   character to its position mod 6, one multiply per cycle. A final word
//   adds a bit-serial modulo for the hash, a second one for the double-hash
//   step in double mode, then an S_PRD and S_PCHK pair per probe.
// Reset: rst_n is synchronous; the block then clears every table memory
//   entry, one entry a cycle, with in_ready low.
// Stall: the result waits in an output register; characters are still
//   accepted, and only the next final word blocks on it.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module open_address_hash_insert_top
  import oah_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int KEY_LEN     = DEF_KEY_LEN
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_key_char,
  input  logic               in_key_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [9:0]         out_slot_index,
  output logic [10:0]        out_probe_count,
  output logic [1:0]         out_status,
  output logic [10:0]        out_filled_count,
  output logic [31:0]        out_total_probes,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CIDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]   cfg_data
);

  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int SW  = AW + 1;
  localparam int CW  = (SW > 11) ? SW : 11;
  localparam int KW  = KEY_LEN * 8;
  localparam int PW  = $clog2(KEY_LEN + 1);

  // state codes
  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_POW  = 4'd2;
  localparam logic [3:0] S_ACC  = 4'd3;
  localparam logic [3:0] S_HDIV = 4'd4;
  localparam logic [3:0] S_SDIV = 4'd5;
  localparam logic [3:0] S_PRD  = 4'd6;
  localparam logic [3:0] S_PCHK = 4'd7;
  localparam logic [3:0] S_EMIT = 4'd8;

  logic [3:0]         state_r;

  // configuration
  logic [TSIZE_W-1:0] slot_limit_r;
  logic               probe_mode_r;
  logic [SPAN_W-1:0]  hash_span_r;

  // key assembly
  logic [KW-1:0]      key_buf_r;
  logic [PW-1:0]      pos_r;
  logic [ACC_W-1:0]   acc_r;
  logic [7:0]         chr_r;
  logic               last_r;
  logic               use_r;
  logic [2:0]         exp_r;
  logic [POW_W-1:0]   pw_r;

  // modulo unit
  logic [ACC_W-1:0]   dq_r;
  logic [SW-1:0]      rem_r;
  logic [5:0]         dcnt_r;

  // probe walk
  logic [AW-1:0]      idx_r;
  logic [AW-1:0]      step_r;
  logic [SW-1:0]      probes_r;
  logic [1:0]         stat_r;
  logic [SW-1:0]      occ_r;
  logic [31:0]        psum_r;
  logic [AW-1:0]      clr_r;

  // table memory: valid bit on top of the key
  logic [KW:0]        mem [TABLE_DEPTH];
  logic [KW:0]        rd_r;
  logic               mem_we;
  logic [AW-1:0]      mem_wa;
  logic [KW:0]        mem_wd;

  // output register
  logic               out_valid_r;
  logic [9:0]         out_slot_r;
  logic [10:0]        out_probes_r;
  logic [1:0]         out_status_r;
  logic [10:0]        out_filled_r;
  logic [31:0]        out_total_r;

  // effective configuration and handshake signals (combinational)
  logic [CW-1:0]      tsz_w;
  logic [SW-1:0]      ts;
  logic [SPAN_W-1:0]  span;
  logic               in_acc;
  logic               emit_go;

  always_comb begin
    tsz_w = CW'(slot_limit_r);
    if (tsz_w == '0) begin
      tsz_w = CW'(1);
    end else if (tsz_w > CW'(TABLE_DEPTH)) begin
      tsz_w = CW'(TABLE_DEPTH);
    end
    ts   = tsz_w[SW-1:0];
    span = (hash_span_r > SPAN_W'(MAX_SPAN)) ? SPAN_W'(MAX_SPAN) : hash_span_r;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  // load the output register when it is empty or being drained
  assign emit_go   = (state_r == S_EMIT) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_limit_r <= TSIZE_W'(TABLE_DEPTH > 1024 ? 1024 : TABLE_DEPTH);
      probe_mode_r <= 1'b0;
      hash_span_r  <= SPAN_W'(MAX_SPAN);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SLOT_LIMIT: slot_limit_r <= cfg_data[TSIZE_W-1:0];
        CFG_PROBE_MODE: probe_mode_r <= cfg_data[0];
        CFG_HASH_SPAN:  hash_span_r  <= cfg_data[SPAN_W-1:0];
        default: ;
      endcase
    end
  end

  // padding: zero characters at positions 0 and 6 contribute 1 each
  logic [1:0]         pad;
  logic [ACC_W-1:0]   acc_nxt;
  logic [SPAN_W-1:0]  pos_w;

  always_comb begin
    pos_w = SPAN_W'(pos_r);
    pad   = 2'd0;
    if (pos_w == '0 && span != '0) pad = pad + 2'd1;
    if (pos_w <= SPAN_W'(POWER_CYCLE) && span > SPAN_W'(POWER_CYCLE)) pad = pad + 2'd1;
    acc_nxt = acc_r + (use_r ? ACC_W'(pw_r) : '0) + (last_r ? ACC_W'(pad) : '0);
  end

  // restoring modulo step
  logic [SW:0]        dtry;
  logic [SW:0]        dsub;
  always_comb begin
    dtry = {rem_r, dq_r[ACC_W-1]};
    dsub = (dtry >= {1'b0, ts}) ? dtry - {1'b0, ts} : dtry;
  end

  // key compare against the read entry
  logic               match;
  logic               done_c;
  always_comb begin
    match  = 1'b1;
    done_c = 1'b0;
    for (int j = 0; j < KEY_LEN; j++) begin
      if (!done_c) begin
        if (fold_case(rd_r[8*j +: 8]) != fold_case(key_buf_r[8*j +: 8])) begin
          match  = 1'b0;
          done_c = 1'b1;
        end else if (rd_r[8*j +: 8] == 8'd0) begin
          done_c = 1'b1;
        end
      end
    end
  end

  logic [SW:0]        nidx;
  logic [SW:0]        nidx_w;
  logic [SW-1:0]      stp1;
  logic [32:0]        psum_add;
  always_comb begin
    nidx     = (SW+1)'(idx_r) + (SW+1)'(step_r);
    nidx_w   = (nidx >= {1'b0, ts}) ? nidx - {1'b0, ts} : nidx;
    stp1     = rem_r + SW'(1);
    psum_add = {1'b0, psum_r} + 33'(probes_r);
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = idx_r;
    mem_wd = {1'b1, key_buf_r};
    if (state_r == S_CLR) begin
      mem_we = 1'b1;
      mem_wa = clr_r;
      mem_wd = '0;
    end else if (state_r == S_PCHK && (!rd_r[KW] || match)) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (state_r == S_PRD) begin
      rd_r <= mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      pos_r       <= '0;
      acc_r       <= '0;
      key_buf_r   <= '0;
      occ_r       <= '0;
      psum_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == AW'(TABLE_DEPTH - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_acc) begin
            chr_r  <= in_key_char;
            last_r <= in_key_last;
            pw_r   <= POW_W'(1);
            use_r  <= (pos_r < PW'(KEY_LEN)) && (SPAN_W'(pos_r) < span);
            exp_r  <= (int'(pos_r) >= POWER_CYCLE) ? 3'(int'(pos_r) - POWER_CYCLE)
                                                   : 3'(pos_r);
            if (pos_r < PW'(KEY_LEN)) begin
              for (int j = 0; j < KEY_LEN; j++) begin
                if (pos_r == PW'(j)) key_buf_r[8*j +: 8] <= in_key_char;
              end
              pos_r <= pos_r + PW'(1);
            end
            state_r <= S_POW;
          end
        end
        S_POW: begin
          if (exp_r != 3'd0) begin
            pw_r  <= POW_W'(pw_r * POW_W'(chr_r));
            exp_r <= exp_r - 3'd1;
          end else begin
            state_r <= S_ACC;
          end
        end
        S_ACC: begin
          if (last_r) begin
            dq_r    <= acc_nxt;
            rem_r   <= '0;
            dcnt_r  <= 6'(ACC_W);
            state_r <= S_HDIV;
          end else begin
            acc_r   <= acc_nxt;
            state_r <= S_IDLE;
          end
        end
        S_HDIV: begin
          rem_r  <= dsub[SW-1:0];
          dq_r   <= dq_r << 1;
          dcnt_r <= dcnt_r - 6'd1;
          if (dcnt_r == 6'd1) begin
            idx_r    <= dsub[AW-1:0];
            probes_r <= '0;
            if (probe_mode_r) begin
              dq_r    <= {key_buf_r[7:0], (ACC_W - 8)'(0)};
              rem_r   <= '0;
              dcnt_r  <= 6'd8;
              state_r <= S_SDIV;
            end else begin
              step_r  <= (ts == SW'(1)) ? '0 : AW'(1);
              state_r <= S_PRD;
            end
          end
        end
        S_SDIV: begin
          rem_r  <= dsub[SW-1:0];
          dq_r   <= dq_r << 1;
          dcnt_r <= dcnt_r - 6'd1;
          if (dcnt_r == 6'd1) begin
            state_r <= S_PRD;
          end
          if (dcnt_r == 6'd0) begin
            state_r <= S_PRD;
          end
        end
        S_PRD: begin
          if (probe_mode_r && dcnt_r == 6'd0) begin
            step_r <= (stp1 == ts) ? '0 : stp1[AW-1:0];
            dcnt_r <= 6'd63;
          end
          state_r <= S_PCHK;
        end
        S_PCHK: begin
          if (!rd_r[KW] || match) begin
            stat_r <= rd_r[KW] ? STAT_FOUND : STAT_NEW;
            if (!rd_r[KW]) occ_r <= occ_r + SW'(1);
            psum_r  <= psum_add[32] ? '1 : psum_add[31:0];
            state_r <= S_EMIT;
          end else if (probes_r >= ts) begin
            stat_r  <= STAT_FULL;
            state_r <= S_EMIT;
          end else begin
            idx_r    <= nidx_w[AW-1:0];
            probes_r <= probes_r + SW'(1);
            state_r  <= S_PRD;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            out_slot_r   <= (stat_r == STAT_FULL) ? 10'd0 : 10'(CW'(idx_r));
            out_probes_r <= 11'(CW'(probes_r));
            out_status_r <= stat_r;
            out_filled_r <= 11'(CW'(occ_r));
            out_total_r  <= psum_r;
            key_buf_r    <= '0;
            pos_r        <= '0;
            acc_r        <= '0;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_slot_index   = out_slot_r;
  assign out_probe_count  = out_probes_r;
  assign out_status       = out_status_r;
  assign out_filled_count = out_filled_r;
  assign out_total_probes = out_total_r;

  `AST_IMP(a_idx_in_range, state_r == S_PCHK, SW'(idx_r) < ts)
  `AST_IMP(a_full_slot_zero, out_valid_r && out_status_r == STAT_FULL, out_slot_r == 10'd0)
  `AST_IMP(a_no_input_in_clear, state_r == S_CLR, !in_ready)
  `AST_NXT(a_new_fills, state_r == S_PCHK && !rd_r[KW], occ_r == $past(occ_r) + SW'(1))

endmodule
